// ===== design/tcpop_pkg.sv =====
`default_nettype none

package tcpop_pkg;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TRUNC     = 2'd1;
    localparam logic [1:0] STAT_MALFORMED = 2'd2;

    localparam logic [7:0] KIND_NOP_MAX = 8'd2;
    localparam logic [7:0] KIND_MSS     = 8'd2;
    localparam logic [7:0] KIND_WSCALE  = 8'd3;
    localparam logic [7:0] KIND_TS      = 8'd8;

    localparam logic [5:0] BASE_HDR_LEN  = 6'd20;
    localparam logic [5:0] OFFSET_POS    = 6'd12;
    localparam logic [5:0] BODY_KEEP_END = 6'd10;
    localparam logic [3:0] BODY_KEEP_MAX = 4'd8;

    typedef struct packed {
        logic        opt_valid;
        logic [7:0]  kind;
        logic [7:0]  len;
        logic [1:0]  status;
        logic        done;
        logic [3:0]  nbytes;
        logic [63:0] value;
    } tcpop_desc_t;

endpackage

`default_nettype wire

// ===== design/tcp_option_parser.sv =====
// TCP header option parser.
// Input channel (in_valid/in_ready): one segment byte per beat in wire order,
// first_byte set on byte 0 of each header. Byte 12 sets the header length;
// bytes 20 up to the header end are walked as options.
// Output channel (out_valid/out_ready): one beat per completed option, per
// truncated or malformed option, or one empty beat (opt_valid 0) when a
// header carries no option ending on its last byte. header_done marks the
// last beat of a header. Bytes after the header end give nothing until the
// next first_byte.
// Each result passes through two registers in order: the walker's descriptor
// register, then the formatting/output register.
// Throughput: one byte per cycle; in_ready drops only while both the
// descriptor and output registers are full and out_ready is low.
// Stall: a held output back-pressures the descriptor register, then the input.
// Reset: rst_n clears the walker to idle, waiting for a first_byte beat, and
// empties both registers.
`default_nettype none

module tcp_option_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  hdr_byte,
    input  wire logic        first_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             opt_valid,
    output logic [7:0]       opt_kind,
    output logic [7:0]       opt_len,
    output logic [15:0]      max_segment,
    output logic [7:0]       win_shift,
    output logic [31:0]      ts_value,
    output logic [31:0]      ts_echo,
    output logic [1:0]       status,
    output logic             header_done
);
    import tcpop_pkg::*;

    logic        desc_valid;
    logic        desc_ready;
    tcpop_desc_t desc;

    tcpop_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hdr_byte   (hdr_byte),
        .first_byte (first_byte),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc)
    );

    tcpop_format u_format (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_valid  (desc_valid),
        .desc_ready  (desc_ready),
        .desc        (desc),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .opt_valid   (opt_valid),
        .opt_kind    (opt_kind),
        .opt_len     (opt_len),
        .max_segment (max_segment),
        .win_shift   (win_shift),
        .ts_value    (ts_value),
        .ts_echo     (ts_echo),
        .status      (status),
        .header_done (header_done)
    );

endmodule

`default_nettype wire

// ===== design/tcpop_walker.sv =====
`default_nettype none

module tcpop_walker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         hdr_byte,
    input  wire logic               first_byte,
    output logic                    desc_valid,
    input  wire logic               desc_ready,
    output tcpop_pkg::tcpop_desc_t  desc
);
    import tcpop_pkg::*;

    logic [5:0]  pos_reg, pos_next, pos_e;
    logic [5:0]  hlen_reg, hlen_next, hlen_e;
    logic [7:0]  kind_reg, kind_next, kind_e;
    logic [7:0]  olen_reg, olen_next, olen_e;
    logic [5:0]  bio_reg, bio_next, bio_e, bio_inc;
    logic [63:0] shift_reg, shift_next, shift_e;
    logic        idle_reg, idle_next, idle_e;
    logic        last, push, malformed;
    logic [3:0]  nb;
    tcpop_desc_t res;
    tcpop_desc_t desc_reg;
    logic        desc_valid_reg;
    logic        in_fire;

    assign in_ready   = !desc_valid_reg || desc_ready;
    assign in_fire    = in_valid && in_ready;
    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

    always_comb
    begin
        pos_e   = first_byte ? 6'd0 : pos_reg;
        hlen_e  = first_byte ? BASE_HDR_LEN : hlen_reg;
        kind_e  = first_byte ? 8'd0 : kind_reg;
        olen_e  = first_byte ? 8'd0 : olen_reg;
        bio_e   = first_byte ? 6'd0 : bio_reg;
        shift_e = first_byte ? 64'd0 : shift_reg;
        idle_e  = first_byte ? 1'b0 : idle_reg;

        pos_next   = pos_e;
        hlen_next  = hlen_e;
        kind_next  = kind_e;
        olen_next  = olen_e;
        bio_next   = bio_e;
        shift_next = shift_e;
        idle_next  = idle_e;
        bio_inc    = bio_e + 6'd1;
        nb         = (bio_inc >= BODY_KEEP_END) ? BODY_KEEP_MAX : 4'(bio_inc - 6'd2);
        last       = 1'b0;
        push       = 1'b0;
        malformed  = 1'b0;
        res        = '0;

        if (!idle_e)
        begin
            pos_next = pos_e + 6'd1;
            if (pos_e == OFFSET_POS)
            begin
                hlen_next = (hdr_byte[7:4] < 4'd5) ? BASE_HDR_LEN : {hdr_byte[7:4], 2'b00};
            end
            last = ({1'b0, pos_e} + 7'd1) == {1'b0, hlen_next};

            if (pos_e >= BASE_HDR_LEN)
            begin
                if (bio_e == 6'd0)
                begin
                    if (hdr_byte < KIND_NOP_MAX)
                    begin
                        push          = 1'b1;
                        res.opt_valid = 1'b1;
                        res.kind      = hdr_byte;
                        res.len       = 8'd1;
                        res.status    = STAT_OK;
                        res.done      = last;
                    end
                    else
                    begin
                        kind_next  = hdr_byte;
                        bio_next   = 6'd1;
                        shift_next = '0;
                        if (last)
                        begin
                            push          = 1'b1;
                            res.opt_valid = 1'b1;
                            res.kind      = hdr_byte;
                            res.status    = STAT_TRUNC;
                            res.done      = 1'b1;
                        end
                    end
                end
                else if (bio_e == 6'd1)
                begin
                    if (hdr_byte < KIND_NOP_MAX)
                    begin
                        push          = 1'b1;
                        malformed     = 1'b1;
                        res.opt_valid = 1'b1;
                        res.kind      = kind_e;
                        res.len       = hdr_byte;
                        res.status    = STAT_MALFORMED;
                        res.done      = 1'b1;
                    end
                    else
                    begin
                        olen_next = hdr_byte;
                        bio_next  = 6'd2;
                        if (hdr_byte == 8'd2)
                        begin
                            push          = 1'b1;
                            res.opt_valid = 1'b1;
                            res.kind      = kind_e;
                            res.len       = hdr_byte;
                            res.status    = STAT_OK;
                            res.done      = last;
                            kind_next     = '0;
                            olen_next     = '0;
                            bio_next      = '0;
                            shift_next    = '0;
                        end
                        else if (last)
                        begin
                            push          = 1'b1;
                            res.opt_valid = 1'b1;
                            res.kind      = kind_e;
                            res.len       = hdr_byte;
                            res.status    = STAT_TRUNC;
                            res.done      = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (bio_e < BODY_KEEP_END)
                    begin
                        shift_next = {shift_e[55:0], hdr_byte};
                    end
                    bio_next = bio_inc;
                    if ({2'b00, bio_inc} == olen_e)
                    begin
                        push          = 1'b1;
                        res.opt_valid = 1'b1;
                        res.kind      = kind_e;
                        res.len       = olen_e;
                        res.status    = STAT_OK;
                        res.done      = last;
                        res.nbytes    = nb;
                        res.value     = shift_next;
                        kind_next     = '0;
                        olen_next     = '0;
                        bio_next      = '0;
                        shift_next    = '0;
                    end
                    else if (last)
                    begin
                        push          = 1'b1;
                        res.opt_valid = 1'b1;
                        res.kind      = kind_e;
                        res.len       = olen_e;
                        res.status    = STAT_TRUNC;
                        res.done      = 1'b1;
                        res.nbytes    = nb;
                        res.value     = shift_next;
                    end
                end
            end

            if (malformed || last)
            begin
                if (!push)
                begin
                    push     = 1'b1;
                    res      = '0;
                    res.done = 1'b1;
                end
                kind_next  = '0;
                olen_next  = '0;
                bio_next   = '0;
                shift_next = '0;
                idle_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            hlen_reg       <= BASE_HDR_LEN;
            kind_reg       <= '0;
            olen_reg       <= '0;
            bio_reg        <= '0;
            shift_reg      <= '0;
            idle_reg       <= 1'b1;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pos_reg   <= pos_next;
                hlen_reg  <= hlen_next;
                kind_reg  <= kind_next;
                olen_reg  <= olen_next;
                bio_reg   <= bio_next;
                shift_reg <= shift_next;
                idle_reg  <= idle_next;
            end
            if (in_ready)
            begin
                desc_valid_reg <= in_valid && push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && push)
        begin
            desc_reg <= res;
        end
    end

`ifndef ASSERT_OFF
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && push && res.done) |=> idle_reg)
        else $error("header end did not return walker to idle");

    a_pos_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        !idle_reg |-> (pos_reg < hlen_reg))
        else $error("byte position past header end while walking");

    a_malformed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (desc_valid_reg && desc_reg.status == STAT_MALFORMED) |-> desc_reg.done)
        else $error("malformed option beat not marked last");

    a_nbytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg |-> (desc_reg.nbytes <= BODY_KEEP_MAX))
        else $error("kept body byte count out of range");
`endif

endmodule

`default_nettype wire

// ===== design/tcpop_format.sv =====
`default_nettype none

module tcpop_format (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    desc_valid,
    output logic                         desc_ready,
    input  wire tcpop_pkg::tcpop_desc_t  desc,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         opt_valid,
    output logic [7:0]                   opt_kind,
    output logic [7:0]                   opt_len,
    output logic [15:0]                  max_segment,
    output logic [7:0]                   win_shift,
    output logic [31:0]                  ts_value,
    output logic [31:0]                  ts_echo,
    output logic [1:0]                   status,
    output logic                         header_done
);
    import tcpop_pkg::*;

    logic        out_valid_reg;
    logic [63:0] full;
    logic [15:0] mss_next;
    logic [7:0]  wsh_next;
    logic [31:0] tsv_next;
    logic [31:0] tse_next;
    logic        opt_valid_reg;
    logic [7:0]  opt_kind_reg;
    logic [7:0]  opt_len_reg;
    logic [15:0] mss_reg;
    logic [7:0]  wsh_reg;
    logic [31:0] tsv_reg;
    logic [31:0] tse_reg;
    logic [1:0]  status_reg;
    logic        done_reg;

    assign desc_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (desc.nbytes == 4'd0)
        begin
            full = '0;
        end
        else
        begin
            full = desc.value << {3'(BODY_KEEP_MAX - desc.nbytes), 3'b000};
        end
        mss_next = '0;
        wsh_next = '0;
        tsv_next = '0;
        tse_next = '0;
        if (desc.opt_valid)
        begin
            case (desc.kind)
                KIND_MSS:    mss_next = full[63:48];
                KIND_WSCALE: wsh_next = full[63:56];
                KIND_TS:
                begin
                    tsv_next = full[63:32];
                    tse_next = full[31:0];
                end
                default:     mss_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (desc_ready)
        begin
            out_valid_reg <= desc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_valid && desc_ready)
        begin
            opt_valid_reg <= desc.opt_valid;
            opt_kind_reg  <= desc.kind;
            opt_len_reg   <= desc.len;
            mss_reg       <= mss_next;
            wsh_reg       <= wsh_next;
            tsv_reg       <= tsv_next;
            tse_reg       <= tse_next;
            status_reg    <= desc.status;
            done_reg      <= desc.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign opt_valid   = opt_valid_reg;
    assign opt_kind    = opt_kind_reg;
    assign opt_len     = opt_len_reg;
    assign max_segment = mss_reg;
    assign win_shift   = wsh_reg;
    assign ts_value    = tsv_reg;
    assign ts_echo     = tse_reg;
    assign status      = status_reg;
    assign header_done = done_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import tcpop_pkg::*;

    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] MIN_OPT_LEN = 8'd2;
    localparam int LEN_MSS      = 4;
    localparam int LEN_WSCALE   = 3;
    localparam int LEN_TS       = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_BYTES  = 240;

    typedef struct {
        logic        valid;
        logic [7:0]  kind;
        logic [7:0]  len;
        logic [15:0] mss;
        logic [7:0]  wshift;
        logic [31:0] tsval;
        logic [31:0] tsecr;
        logic [1:0]  stat;
        logic        done;
    } opt_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  hdr_byte;
    logic        first_byte;
    logic        out_valid;
    logic        out_ready;
    logic        opt_valid;
    logic [7:0]  opt_kind;
    logic [7:0]  opt_len;
    logic [15:0] max_segment;
    logic [7:0]  win_shift;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic [1:0]  status;
    logic        header_done;

    logic [5:0]  walk_pos;
    logic [5:0]  hdr_end;
    logic [7:0]  walk_kind;
    logic [7:0]  walk_len;
    logic [7:0]  walk_count;
    logic [63:0] body_shift;
    bit          walk_idle;

    opt_result_t expected_opts[$];
    opt_result_t head_opt;
    logic [7:0]  frame_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int cycle_count;
    int opts_checked;
    int bytes_walked;
    int headers_sent;

    tcp_option_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .hdr_byte    (hdr_byte),
        .first_byte  (first_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .opt_valid   (opt_valid),
        .opt_kind    (opt_kind),
        .opt_len     (opt_len),
        .max_segment (max_segment),
        .win_shift   (win_shift),
        .ts_value    (ts_value),
        .ts_echo     (ts_echo),
        .status      (status),
        .header_done (header_done)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_walk();
        walk_kind  = 8'd0;
        walk_len   = 8'd0;
        walk_count = 8'd0;
        body_shift = 64'd0;
    endfunction

    function automatic opt_result_t format_option(input logic v, input logic [7:0] k,
                                                  input logic [7:0] l, input logic [1:0] st,
                                                  input logic d);
        opt_result_t r;
        logic [63:0] full;
        int n;
        r = '{default: '0};
        full = 64'd0;
        n = 0;
        r.valid = v;
        r.done = d;
        if (!v)
            return r;
        r.kind = k;
        r.len = l;
        r.stat = st;
        if (st != STAT_MALFORMED && walk_count > 8'd2)
        begin
            n = int'(walk_count) - 2;
            if (n > 8)
                n = 8;
        end
        if (n == 8)
            full = body_shift;
        else if (n > 0)
            full = body_shift << ((8 - n) * 8);
        case (k)
            KIND_MSS:    r.mss = full[63:48];
            KIND_WSCALE: r.wshift = full[63:56];
            KIND_TS:
            begin
                r.tsval = full[63:32];
                r.tsecr = full[31:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic f,
                                      output opt_result_t r);
        bit produced;
        bit last;
        int p;
        produced = 1'b0;
        r = '{default: '0};
        if (f)
        begin
            walk_pos = 6'd0;
            hdr_end = BASE_HDR_LEN;
            clear_walk();
            walk_idle = 1'b0;
        end
        if (walk_idle)
            return 1'b0;
        p = int'(walk_pos);
        if (walk_pos == OFFSET_POS)
            hdr_end = (b[7:4] < 4'd5) ? BASE_HDR_LEN : {b[7:4], 2'b00};
        last = (p + 1 == int'(hdr_end));
        if (p >= int'(BASE_HDR_LEN))
        begin
            if (walk_count == 8'd0)
            begin
                if (b < KIND_NOP_MAX)
                begin
                    r = format_option(1'b1, b, 8'd1, STAT_OK, last);
                    produced = 1'b1;
                end
                else
                begin
                    walk_kind = b;
                    walk_count = 8'd1;
                    body_shift = 64'd0;
                    if (last)
                    begin
                        r = format_option(1'b1, b, 8'd0, STAT_TRUNC, 1'b1);
                        produced = 1'b1;
                    end
                end
            end
            else if (walk_count == 8'd1)
            begin
                if (b < MIN_OPT_LEN)
                begin
                    r = format_option(1'b1, walk_kind, b, STAT_MALFORMED, 1'b1);
                    clear_walk();
                    walk_idle = 1'b1;
                    walk_pos = 6'(p + 1);
                    return 1'b1;
                end
                walk_len = b;
                walk_count = 8'd2;
                if (b == MIN_OPT_LEN)
                begin
                    r = format_option(1'b1, walk_kind, b, STAT_OK, last);
                    clear_walk();
                    produced = 1'b1;
                end
                else if (last)
                begin
                    r = format_option(1'b1, walk_kind, b, STAT_TRUNC, 1'b1);
                    produced = 1'b1;
                end
            end
            else
            begin
                if (walk_count - 8'd2 < 8'd8)
                    body_shift = {body_shift[55:0], b};
                walk_count = walk_count + 8'd1;
                if (walk_count == walk_len)
                begin
                    r = format_option(1'b1, walk_kind, walk_len, STAT_OK, last);
                    clear_walk();
                    produced = 1'b1;
                end
                else if (last)
                begin
                    r = format_option(1'b1, walk_kind, walk_len, STAT_TRUNC, 1'b1);
                    produced = 1'b1;
                end
            end
        end
        if (last)
        begin
            if (!produced)
            begin
                r = format_option(1'b0, 8'd0, 8'd0, STAT_OK, 1'b1);
                produced = 1'b1;
            end
            clear_walk();
            walk_idle = 1'b1;
        end
        walk_pos = 6'(p + 1);
        return produced;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_opts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat expected none actual kind %0h len %0h done %0b",
                         $time, opt_kind, opt_len, header_done);
            end
            else
            begin
                head_opt = expected_opts.pop_front();
                opts_checked++;
                check_field("opt_valid", head_opt.valid, opt_valid);
                check_field("opt_kind", head_opt.kind, opt_kind);
                check_field("opt_len", head_opt.len, opt_len);
                check_field("max_segment", head_opt.mss, max_segment);
                check_field("win_shift", head_opt.wshift, win_shift);
                check_field("ts_value", head_opt.tsval, ts_value);
                check_field("ts_echo", head_opt.tsecr, ts_echo);
                check_field("status", head_opt.stat, status);
                check_field("header_done", head_opt.done, header_done);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f);
        int gap;
        opt_result_t r;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        hdr_byte <= b;
        first_byte <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (f || !walk_idle)
            bytes_walked++;
        if (parse_byte(b, f, r))
            expected_opts.push_back(r);
    endtask

    task automatic pause_input();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        pause_input();
        while (expected_opts.size() != 0)
            @(posedge clk);
    endtask

    task automatic start_frame(input logic [3:0] off, input bit rand_fill,
                               input logic [7:0] fill);
        for (int i = 0; i < int'(BASE_HDR_LEN); i++)
            frame_q.push_back(rand_fill ? 8'($urandom) : fill);
        frame_q[OFFSET_POS] = {off, frame_q[OFFSET_POS][3:0]};
    endtask

    task automatic add_bytes(input logic [7:0] bytes[]);
        foreach (bytes[i])
            frame_q.push_back(bytes[i]);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == 0);
        frame_q.delete();
        headers_sent++;
    endtask

    task automatic test_idle_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_no_options();
        start_frame(4'd5, 1'b0, 8'hFF);
        add_bytes('{8'hFF, 8'h00});
        send_frame();
        start_frame(4'd0, 1'b0, 8'h00);
        send_frame();
        start_frame(4'd4, 1'b0, 8'hFF);
        send_frame();
    endtask

    task automatic test_common_kinds();
        start_frame(4'd8, 1'b0, 8'h00);
        add_bytes('{KIND_EOL, KIND_NOP, KIND_MSS, 8'd4, 8'hFF, 8'hFF,
                    KIND_WSCALE, 8'd3, 8'h0E, KIND_NOP, KIND_NOP, KIND_NOP});
        send_frame();
        start_frame(4'd8, 1'b0, 8'hFF);
        add_bytes('{KIND_TS, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h80, 8'h00, 8'h00, 8'h01, KIND_EOL, KIND_EOL});
        send_frame();
    endtask

    task automatic test_long_body();
        start_frame(4'd15, 1'b1, 8'h00);
        frame_q.push_back(8'hFE);
        frame_q.push_back(8'd14);
        for (int i = 1; i <= 12; i++)
            frame_q.push_back(8'(i));
        add_bytes('{KIND_MSS, MIN_OPT_LEN, KIND_TS, 8'hFF});
        for (int i = 0; i < 22; i++)
            frame_q.push_back(8'(8'h10 + i));
        send_frame();
    endtask

    task automatic test_truncation();
        start_frame(4'd6, 1'b1, 8'h00);
        add_bytes('{KIND_NOP, KIND_NOP, KIND_NOP, KIND_TS});
        send_frame();
        start_frame(4'd6, 1'b1, 8'h00);
        add_bytes('{KIND_NOP, KIND_NOP, KIND_WSCALE, 8'd9});
        send_frame();
        start_frame(4'd6, 1'b1, 8'h00);
        add_bytes('{KIND_NOP, KIND_MSS, 8'd10, 8'h12});
        send_frame();
    endtask

    task automatic test_malformed();
        start_frame(4'd8, 1'b1, 8'h00);
        add_bytes('{8'h05, 8'h00, KIND_NOP, KIND_EOL, KIND_MSS, 8'd4,
                    8'h05, 8'hB4, KIND_NOP, KIND_NOP, KIND_NOP, KIND_NOP});
        send_frame();
        start_frame(4'd6, 1'b1, 8'h00);
        add_bytes('{8'h1E, 8'h01, KIND_EOL, KIND_NOP});
        send_frame();
    endtask

    task automatic test_restart();
        start_frame(4'd10, 1'b1, 8'h00);
        add_bytes('{KIND_TS, 8'd10, 8'h11, 8'h22, 8'h33});
        send_frame();
        start_frame(4'd6, 1'b1, 8'h00);
        add_bytes('{KIND_WSCALE, 8'd3, 8'h07, KIND_NOP});
        send_frame();
    endtask

    task automatic send_random_header();
        int off_sel;
        int hlen;
        int mode;
        int pick;
        int olen;
        int corrupt_pct;
        int cut;
        logic [3:0] off;
        logic [7:0] kind;
        off_sel = $urandom_range(99);
        if (off_sel < 10)
            off = 4'($urandom_range(4));
        else if (off_sel < 20)
            off = 4'd5;
        else
            off = 4'($urandom_range(15, 6));
        start_frame(off, 1'b1, 8'h00);
        hlen = (off < 4'd5) ? int'(BASE_HDR_LEN) : int'(off) * 4;
        mode = $urandom_range(99);
        if (mode < 13)
        begin
            while (frame_q.size() < hlen)
                frame_q.push_back(8'($urandom));
        end
        else
        begin
            corrupt_pct = (mode < 25) ? 30 : 0;
            while (frame_q.size() < hlen)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    frame_q.push_back(KIND_EOL);
                else if (pick < 30)
                    frame_q.push_back(KIND_NOP);
                else
                begin
                    if (pick < 50)
                    begin
                        kind = KIND_MSS;
                        olen = LEN_MSS;
                    end
                    else if (pick < 62)
                    begin
                        kind = KIND_WSCALE;
                        olen = LEN_WSCALE;
                    end
                    else if (pick < 80)
                    begin
                        kind = KIND_TS;
                        olen = LEN_TS;
                    end
                    else
                    begin
                        kind = 8'($urandom_range(255, 2));
                        olen = ($urandom_range(9) == 0) ? $urandom_range(255, 15)
                                                        : $urandom_range(14, 2);
                    end
                    if ($urandom_range(99) < corrupt_pct)
                        olen = $urandom_range(1);
                    frame_q.push_back(kind);
                    frame_q.push_back(8'(olen));
                    for (int i = 2; i < olen && frame_q.size() < hlen + 4; i++)
                        frame_q.push_back(8'($urandom));
                end
            end
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom));
        if ($urandom_range(9) == 0)
        begin
            cut = $urandom_range(frame_q.size() - 1, 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
        send_frame();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct);
        int stop_at;
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = bytes_walked + PHASE_BYTES;
        while (bytes_walked < stop_at)
            send_random_header();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        hdr_byte = 8'd0;
        first_byte = 1'b0;
        out_ready = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 77;
        errors = 0;
        cycle_count = 0;
        opts_checked = 0;
        bytes_walked = 0;
        headers_sent = 0;
        walk_pos = 6'd0;
        hdr_end = BASE_HDR_LEN;
        clear_walk();
        walk_idle = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_no_options();
        test_common_kinds();
        test_long_body();
        test_truncation();
        test_malformed();
        test_restart();
        test_random_phase(13, 77);
        test_random_phase(77, 13);
        test_random_phase(0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d headers, %0d walked bytes; checked %0d result beats",
                 headers_sent, bytes_walked, opts_checked);
        $display("Covered common kinds, long bodies, truncation, bad lengths, restarts");
        if (errors == 0 && expected_opts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
